// File: rtl/core/cp1252_to_escaped_utf8_macros.svh
// Assertion helpers used by the checker file.
`ifndef CP1252_TO_ESCAPED_UTF8_MACROS_SVH
`define CP1252_TO_ESCAPED_UTF8_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CP2U8_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cp2u8 check failed");

// Next-cycle implication, disabled in reset.
`define CP2U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cp2u8 check failed");

`endif

// File: rtl/core/cp2u8_pkg.sv
package cp2u8_pkg;

  // Bytes of one encoded group and default queue depth (groups)
  localparam int unsigned GROUP_BYTES = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_SPACE     = 8'h20;

  // Windows-1252 remapped range
  localparam logic [7:0] C1_LO = 8'h80;
  localparam logic [7:0] C1_HI = 8'h9F;

  // UTF-8 length limits and marker bits
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [7:0]  LEAD2          = 8'hC0;
  localparam logic [7:0]  LEAD3          = 8'hE0;
  localparam logic [7:0]  CONT           = 8'h80;

  // One encoded character: bytes[0] goes out first
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [1:0]                  nbytes;
  } group_t;

  typedef enum logic [2:0] {
    CLS_CONTROL,
    CLS_PLAIN,
    CLS_ESCAPED,
    CLS_TWO,
    CLS_THREE
  } cls_t;

  // Code points for 0x80..0x9F
  localparam logic [15:0] CP_TABLE [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  function automatic logic [15:0] decode_cp(logic [7:0] b);
    logic [15:0] cp;
    if (b >= C1_LO && b <= C1_HI) begin
      cp = CP_TABLE[b[4:0]];
    end else begin
      cp = {8'h00, b};
    end
    return cp;
  endfunction

  function automatic cls_t classify(logic [15:0] cp);
    cls_t cls;
    priority if (cp < {8'h00, CHR_SPACE}) begin
      cls = CLS_CONTROL;
    end else if (cp < ONE_BYTE_LIMIT) begin
      if (cp[7:0] == CHR_QUOTE || cp[7:0] == CHR_BACKSLASH) begin
        cls = CLS_ESCAPED;
      end else begin
        cls = CLS_PLAIN;
      end
    end else if (cp < TWO_BYTE_LIMIT) begin
      cls = CLS_TWO;
    end else begin
      cls = CLS_THREE;
    end
    return cls;
  endfunction

  function automatic group_t build(cls_t cls, logic [15:0] cp);
    group_t g;
    g = '0;
    unique case (cls)
      CLS_CONTROL: begin
        g.nbytes = 2'd0;
      end
      CLS_PLAIN: begin
        g.bytes[0] = cp[7:0];
        g.nbytes   = 2'd1;
      end
      CLS_ESCAPED: begin
        g.bytes[0] = CHR_BACKSLASH;
        g.bytes[1] = cp[7:0];
        g.nbytes   = 2'd2;
      end
      CLS_TWO: begin
        g.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
        g.bytes[1] = CONT | {2'b00, cp[5:0]};
        g.nbytes   = 2'd2;
      end
      CLS_THREE: begin
        g.bytes[0] = LEAD3 | {4'h0, cp[15:12]};
        g.bytes[1] = CONT | {2'b00, cp[11:6]};
        g.bytes[2] = CONT | {2'b00, cp[5:0]};
        g.nbytes   = 2'd3;
      end
      default: begin
        g.nbytes = 2'd0;
      end
    endcase
    return g;
  endfunction

endpackage

// File: rtl/core/cp2u8_if.sv
// Byte input channel
interface cp2u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Encoded output channel
interface cp2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/core/cp1252_to_escaped_utf8.sv
// An accepted input beat is written into the group queue, then loaded into the serializer's held group.
// Throughput: one input beat per cycle while the group queue is not full; each character then
//   takes one output beat per UTF-8 / escape byte (none for control bytes), so the output port sets the sustained rate.
// A QDEPTH-entry group queue between classifier and serializer absorbs output bursts.
// Reset (rst, synchronous): empties the queue and the output stage; no other state.
module cp1252_to_escaped_utf8
  import cp2u8_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input logic         clk,
  input logic         rst,
  cp2u8_in_if.sink    raw,
  cp2u8_out_if.source enc
);

  logic   push;
  group_t push_group;
  logic   full;
  logic   pop;
  group_t head;
  logic   empty;

  // Classify and encode
  cp2u8_front u_front (
    .raw        (raw),
    .full       (full),
    .push       (push),
    .push_group (push_group)
  );

  // Group queue
  cp2u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  // Serialize groups into beats
  cp2u8_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .enc   (enc)
  );

endmodule

// File: rtl/core/cp2u8_front.sv
module cp2u8_front
  import cp2u8_pkg::*;
(
  cp2u8_in_if.sink raw,
  input  logic     full,
  output logic     push,
  output group_t   push_group
);

  logic [15:0] cp;
  cls_t        cls;

  // Map, classify and encode in one pass
  always_comb begin
    cp         = decode_cp(raw.in_byte);
    cls        = classify(cp);
    push_group = build(cls, cp);
  end

  // Control bytes are accepted and dropped
  assign raw.ready = !full;
  assign push      = raw.valid && !full && (cls != CLS_CONTROL);

endmodule

// File: rtl/core/cp2u8_queue.sv
module cp2u8_queue
  import cp2u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output group_t head,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr_next;
  logic [CNT_W-1:0]   count_next;

  // Pointer wrap and occupancy count
  always_comb begin
    wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

endmodule

// File: rtl/core/cp2u8_back.sv
module cp2u8_back
  import cp2u8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  group_t    head,
  input  logic      empty,
  output logic      pop,
  cp2u8_out_if.source enc
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       take;
  logic       done;

  // Beat sequencing over the held group
  assign last = (idx == cur.nbytes - 2'd1);
  assign take = cur_valid && enc.ready;
  assign done = !cur_valid || (take && last);
  assign pop  = done && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= !empty;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  // Held group, reloaded from the queue head
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  assign enc.valid       = cur_valid;
  assign enc.out_byte    = cur.bytes[idx];
  assign enc.last_of_run = last;

endmodule

// File: rtl/core/cp2u8_checker.sv
`include "cp1252_to_escaped_utf8_macros.svh"

module cp2u8_checker
  import cp2u8_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic in_take;
  logic out_take;
  logic out_stall;
  logic out_lead;
  logic out_cont;
  logic out_esc;
  logic out_esc_chr;
  logic out_plain;

  assign in_take     = in_valid && in_ready;
  assign out_take    = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_lead    = (out_byte[7:6] == 2'b11);
  assign out_cont    = (out_byte[7:6] == 2'b10);
  assign out_esc     = (out_byte == CHR_BACKSLASH);
  assign out_esc_chr = (out_byte == CHR_QUOTE) || (out_byte == CHR_BACKSLASH);
  assign out_plain   = !out_byte[7] && !out_esc;

  // Stalled output beat holds
  `CP2U8_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable({out_byte, out_last}))

  // A character's beats come without gaps
  `CP2U8_ASSERT_NEXT(a_run_gapless, clk, rst, out_take && !out_last, out_valid)

  // A UTF-8 lead byte is followed by a continuation byte
  `CP2U8_ASSERT_NEXT(a_lead_cont, clk, rst, out_take && !out_last && out_lead, out_cont)

  // Plain ASCII other than backslash always ends its run
  `CP2U8_ASSERT_NOW(a_ascii_last, clk, rst, out_valid && out_plain, out_last)

  // Escape prefix is followed by quote or backslash (checked only when no input beat is taken in that cycle)
  `CP2U8_ASSERT_NEXT(a_escape, clk, rst, out_take && !out_last && out_esc && !in_take, out_esc_chr)

endmodule

bind cp1252_to_escaped_utf8 cp2u8_checker u_cp2u8_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (raw.valid),
  .in_ready  (raw.ready),
  .out_valid (enc.valid),
  .out_ready (enc.ready),
  .out_byte  (enc.out_byte),
  .out_last  (enc.last_of_run)
);

// File: dv/tb_cp1252_to_escaped_utf8.sv
`timescale 1ns / 100ps

module tb_cp1252_to_escaped_utf8
  import cp2u8_pkg::*;
();

  localparam int unsigned RANDOM_PRINTABLE = 135;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned SETTLE_CYCLES    = 12;

  // Code points for Windows-1252 bytes 0x80..0x9F
  localparam logic [15:0] WIN1252_HIGH_CP [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  typedef struct {
    logic [7:0] value;
    bit         drain_first;  // hold this char until all output has come back
  } char_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  logic clk;
  logic rst;

  cp2u8_in_if  raw ();
  cp2u8_out_if enc ();

  cp1252_to_escaped_utf8 uut (
    .clk (clk),
    .rst (rst),
    .raw (raw),
    .enc (enc)
  );

  char_item_t  pending_chars[$];
  utf8_beat_t  utf8_expected[$];
  int unsigned total_chars;
  int unsigned chars_accepted;
  int unsigned mismatches;
  int unsigned cycles;

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle percentage for each side; sender and receiver swap rates, then no idling
  function automatic int unsigned idle_pct(bit for_sender);
    if (chars_accepted < total_chars / 3) begin
      return for_sender ? 33 : 46;
    end else if (chars_accepted < (2 * total_chars) / 3) begin
      return for_sender ? 46 : 33;
    end
    return 0;
  endfunction

  // Expected escaped UTF-8 beats for one accepted Windows-1252 byte
  function automatic void predict_utf8(logic [7:0] ch);
    logic [15:0] cp;
    logic [7:0]  seq [3];
    int          n;
    utf8_beat_t  beat;
    n = 0;
    if (ch >= 8'h80 && ch <= 8'h9F) begin
      cp = WIN1252_HIGH_CP[ch[4:0]];
    end else begin
      cp = {8'h00, ch};
    end
    if (cp < 16'h0080) begin
      // control chars vanish; quote and backslash get a backslash in front
      if (cp >= 16'h0020) begin
        if (cp[7:0] == CHR_QUOTE || cp[7:0] == CHR_BACKSLASH) begin
          seq[n] = CHR_BACKSLASH;
          n++;
        end
        seq[n] = cp[7:0];
        n++;
      end
    end else if (cp < 16'h0800) begin
      seq[0] = 8'hC0 | {3'b000, cp[10:6]};
      seq[1] = 8'h80 | {2'b00, cp[5:0]};
      n = 2;
    end else begin
      seq[0] = 8'hE0 | {4'h0, cp[15:12]};
      seq[1] = 8'h80 | {2'b00, cp[11:6]};
      seq[2] = 8'h80 | {2'b00, cp[5:0]};
      n = 3;
    end
    for (int k = 0; k < n; k++) begin
      beat.data = seq[k];
      beat.last = (k == n - 1);
      utf8_expected.insert(utf8_expected.size(), beat);
    end
  endfunction

  function automatic void queue_char(logic [7:0] value, bit drain_first);
    char_item_t item;
    item.value       = value;
    item.drain_first = drain_first;
    pending_chars.insert(pending_chars.size(), item);
  endfunction

  // Driver: presents queued chars on the input channel
  always @(posedge clk) begin : driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    char_item_t item;
    if (rst) begin
      raw.valid   <= 1'b0;
      raw.in_byte <= 8'h00;
    end else begin
      nxt_valid = raw.valid;
      nxt_byte  = raw.in_byte;
      if (raw.valid && raw.ready) begin
        predict_utf8(raw.in_byte);
        chars_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_chars.size() > 0) begin
        if (pending_chars[0].drain_first && utf8_expected.size() > 0) begin
          // hold off until the output side has drained
        end else if ($urandom_range(99) >= idle_pct(1'b1)) begin
          item      = pending_chars.pop_front();
          nxt_valid = 1'b1;
          nxt_byte  = item.value;
        end
      end
      raw.valid   <= nxt_valid;
      raw.in_byte <= nxt_byte;
    end
  end

  // Monitor: checks each output beat against the oldest expectation
  always @(posedge clk) begin : monitor
    utf8_beat_t want;
    if (rst) begin
      enc.ready <= 1'b0;
    end else begin
      if (enc.valid && enc.ready) begin
        if (utf8_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte=%02h last=%0b",
                   $time, enc.out_byte, enc.last_of_run);
          mismatches++;
        end else begin
          want = utf8_expected.pop_front();
          if (enc.out_byte !== want.data || enc.last_of_run !== want.last) begin
            $display("%0t: mismatch, expected byte=%02h last=%0b, actual byte=%02h last=%0b",
                     $time, want.data, want.last, enc.out_byte, enc.last_of_run);
            mismatches++;
          end
        end
      end
      enc.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0]  ch;
    int unsigned printable;
    int unsigned pick;
    rst = 1'b1;

    // Directed: control edges, escapes, DEL, every length, unassigned C1 slots, Latin-1 edges
    queue_char(8'h00, 1'b0);
    queue_char(8'h1F, 1'b0);
    queue_char(8'h20, 1'b0);
    queue_char(CHR_QUOTE, 1'b0);
    queue_char(CHR_BACKSLASH, 1'b0);
    queue_char(8'h41, 1'b0);
    queue_char(8'h7E, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h81, 1'b0);
    queue_char(8'h83, 1'b0);
    queue_char(8'h88, 1'b0);
    queue_char(8'h8A, 1'b0);
    queue_char(8'h8D, 1'b0);
    queue_char(8'h8F, 1'b0);
    queue_char(8'h90, 1'b0);
    queue_char(8'h99, 1'b0);
    queue_char(8'h9D, 1'b0);
    queue_char(8'h9E, 1'b0);
    queue_char(8'h9F, 1'b0);
    queue_char(8'hA0, 1'b0);
    queue_char(8'hFF, 1'b0);

    // Random: weighted toward the interesting classes, control chars as noise
    printable = 0;
    while (printable < RANDOM_PRINTABLE) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        ch = 8'($urandom_range(8'h1F, 8'h00));
      end else if (pick < 30) begin
        ch = 8'($urandom_range(8'h9F, 8'h80));
      end else if (pick < 40) begin
        ch = $urandom_range(1) ? CHR_QUOTE : CHR_BACKSLASH;
      end else if (pick < 70) begin
        ch = 8'($urandom_range(8'h7F, 8'h20));
      end else begin
        ch = 8'($urandom_range(8'hFF, 8'hA0));
      end
      // pause the sender right after the directed part and once more midway
      queue_char(ch, printable == 0 || printable == RANDOM_PRINTABLE / 2);
      if (ch >= 8'h20) begin
        printable++;
      end
    end
    total_chars = pending_chars.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || raw.valid || utf8_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && utf8_expected.size() == 0 && pending_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: cp1252_to_escaped_utf8.f
+incdir+rtl/core
rtl/core/cp2u8_pkg.sv
rtl/core/cp2u8_if.sv
rtl/core/cp2u8_front.sv
rtl/core/cp2u8_queue.sv
rtl/core/cp2u8_back.sv
rtl/core/cp1252_to_escaped_utf8.sv
rtl/core/cp2u8_checker.sv
dv/tb_cp1252_to_escaped_utf8.sv
